// ===== sv/tqws_pkg.sv =====
// tqws_pkg: shared types and constants of the three queue watermark scheduler
`default_nettype none

package tqws_pkg;

  // payload widths
  localparam int unsigned MODE_W   = 2;
  localparam int unsigned ID_W     = 16;
  localparam int unsigned TIME_W   = 32;
  localparam int unsigned FILL_W   = 8;
  localparam int unsigned LEVEL_W  = 8;
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 32;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_LANDING_DRAIN = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_DEPARTING_LIM = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_TIME_ORIGIN   = 2'd2;

  // configuration reset values
  localparam logic [LEVEL_W-1:0] LANDING_DRAIN_RST = 8'd15;
  localparam logic [LEVEL_W-1:0] DEPARTING_LIM_RST = 8'd5;
  localparam logic [TIME_W-1:0]  TIME_ORIGIN_RST   = 32'd0;

  typedef enum logic [1:0] {
    MODE_LANDING   = 2'd0,
    MODE_DEPARTING = 2'd1,
    MODE_EMERGENCY = 2'd2,
    MODE_SERVE     = 2'd3
  } mode_e;

  typedef enum logic [1:0] {
    ST_ENQ   = 2'd0,
    ST_DROP  = 2'd1,
    ST_GRANT = 2'd2,
    ST_IDLE  = 2'd3
  } status_e;

  typedef enum logic [1:0] {
    CL_EMERGENCY = 2'd0,
    CL_LANDING   = 2'd1,
    CL_DEPARTING = 2'd2
  } class_e;

  typedef enum logic {
    S_IDLE = 1'b0,
    S_READ = 1'b1
  } state_e;

  // one queue entry as held in the store
  typedef struct packed {
    logic [ID_W-1:0]   id;
    logic [TIME_W-1:0] arrival;
  } slot_t;

  // arbiter decision
  typedef struct packed {
    logic   grant;
    class_e cls;
  } pick_t;

endpackage

`default_nettype wire

// ===== sv/tqws_req_if.sv =====
// tqws_req_if: request channel into the scheduler
`default_nettype none

interface tqws_req_if;
  logic                              valid;
  logic                              ready;
  logic [tqws_pkg::MODE_W-1:0]       mode;
  logic [tqws_pkg::ID_W-1:0]         requester_id;
  logic [tqws_pkg::TIME_W-1:0]       now;

  modport source (output valid, output mode, output requester_id, output now, input ready);
  modport sink   (input valid, input mode, input requester_id, input now, output ready);
endinterface

`default_nettype wire

// ===== sv/tqws_res_if.sv =====
// tqws_res_if: result channel out of the scheduler
`default_nettype none

interface tqws_res_if;
  logic                              valid;
  logic                              ready;
  logic [1:0]                        status;
  logic [1:0]                        queue_class;
  logic [tqws_pkg::ID_W-1:0]         granted_id;
  logic [tqws_pkg::TIME_W-1:0]       rel_time;
  logic [tqws_pkg::TIME_W-1:0]       wait_time;
  logic [tqws_pkg::FILL_W-1:0]       landing_fill;
  logic [tqws_pkg::FILL_W-1:0]       departing_fill;
  logic [tqws_pkg::FILL_W-1:0]       emergency_fill;

  modport source (output valid, output status, output queue_class, output granted_id,
                  output rel_time, output wait_time, output landing_fill,
                  output departing_fill, output emergency_fill, input ready);
  modport sink   (input valid, input status, input queue_class, input granted_id,
                  input rel_time, input wait_time, input landing_fill,
                  input departing_fill, input emergency_fill, output ready);
endinterface

`default_nettype wire

// ===== sv/tqws_arbiter.sv =====
// tqws_arbiter: watermark priority choice between the three queues
`default_nettype none

module tqws_arbiter #(
  parameter int unsigned CNT_W = 8
) (
  input  wire logic [CNT_W-1:0]             em_cnt_i,
  input  wire logic [CNT_W-1:0]             ld_cnt_i,
  input  wire logic [CNT_W-1:0]             dp_cnt_i,
  input  wire logic [tqws_pkg::LEVEL_W-1:0] drain_level_i,
  input  wire logic [tqws_pkg::LEVEL_W-1:0] dep_limit_i,
  output tqws_pkg::pick_t                   pick_o
);

  localparam int unsigned CMP_W = (CNT_W > tqws_pkg::LEVEL_W) ? CNT_W : tqws_pkg::LEVEL_W;

  logic [CMP_W-1:0] ld_ext, dp_ext, drain_ext, limit_ext;
  logic             ld_ok;

  // common width for the threshold compares
  assign ld_ext    = CMP_W'(ld_cnt_i);
  assign dp_ext    = CMP_W'(dp_cnt_i);
  assign drain_ext = CMP_W'(drain_level_i);
  assign limit_ext = CMP_W'(dep_limit_i);

  // landing wins over departing below the limit, at or above the drain level, or with no departing
  assign ld_ok = (ld_ext != '0) &&
                 ((dp_ext < limit_ext) || (ld_ext >= drain_ext) || (dp_ext == '0));

  // strict emergency priority, then landing when ld_ok allows it, then departing
  always_comb begin
    pick_o.grant = 1'b1;
    pick_o.cls   = tqws_pkg::CL_EMERGENCY;
    if (em_cnt_i != '0) begin
      pick_o.cls = tqws_pkg::CL_EMERGENCY;
    end else if (ld_ok) begin
      pick_o.cls = tqws_pkg::CL_LANDING;
    end else if (dp_cnt_i != '0) begin
      pick_o.cls = tqws_pkg::CL_DEPARTING;
    end else begin
      pick_o.grant = 1'b0;
    end
  end

endmodule

`default_nettype wire

// ===== sv/three_queue_watermark_scheduler_core.sv =====
// three_queue_watermark_scheduler_core: three fifo scheduler with watermark arbitration
//
//   channel  | dir | handshake        | payload
//   ---------+-----+------------------+------------------------------------------------
//   req_i    | in  | valid/ready      | mode, requester_id, now
//   res_o    | out | valid/ready      | status, queue_class, granted_id, rel_time,
//            |     |                  | wait_time, landing/departing/emergency_fill
//   cfg      | in  | cfg_we_i, no ack | cfg_idx_i, cfg_data_i
//
// a request is held in an input register and processed once the output register is free
// enqueue, drop and idle results load the output register from the held request once it is free
// a grant first reads the head entry into the registered store output, then loads the output in S_READ
// sustained: one enqueue per cycle while res_o is drained; a serve holds its request through S_READ
// a stalled result blocks processing but one further request is still accepted
// reset clears pointers, counts and control registers; payload registers and the store need no clearing
`default_nettype none

module three_queue_watermark_scheduler_core #(
  parameter int unsigned QUEUE_DEPTH = 128
) (
  input  wire logic                                clk_i,
  input  wire logic                                rst_ni,
  tqws_req_if.sink                                 req_i,
  tqws_res_if.source                               res_o,
  input  wire logic                                cfg_we_i,
  input  wire logic [tqws_pkg::CFG_IDX_W-1:0]      cfg_idx_i,
  input  wire logic [tqws_pkg::CFG_DATA_W-1:0]     cfg_data_i
);

  localparam int unsigned PTR_W  = $clog2(QUEUE_DEPTH);
  localparam int unsigned CNT_W  = $clog2(QUEUE_DEPTH + 1);
  localparam int unsigned ADDR_W = $clog2(3 * QUEUE_DEPTH);
  localparam int unsigned EXT_W  = (CNT_W > tqws_pkg::FILL_W) ? CNT_W : tqws_pkg::FILL_W;

  // configuration registers
  logic [tqws_pkg::LEVEL_W-1:0] drain_q, limit_q;
  logic [tqws_pkg::TIME_W-1:0]  origin_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      drain_q  <= tqws_pkg::LANDING_DRAIN_RST;
      limit_q  <= tqws_pkg::DEPARTING_LIM_RST;
      origin_q <= tqws_pkg::TIME_ORIGIN_RST;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        tqws_pkg::CFG_LANDING_DRAIN: drain_q  <= cfg_data_i[tqws_pkg::LEVEL_W-1:0];
        tqws_pkg::CFG_DEPARTING_LIM: limit_q  <= cfg_data_i[tqws_pkg::LEVEL_W-1:0];
        tqws_pkg::CFG_TIME_ORIGIN:   origin_q <= cfg_data_i[tqws_pkg::TIME_W-1:0];
        default: ;
      endcase
    end
  end

  // queue control state, indexed by class
  logic [PTR_W-1:0] head_q [3];
  logic [PTR_W-1:0] head_d [3];
  logic [PTR_W-1:0] tail_q [3];
  logic [PTR_W-1:0] tail_d [3];
  logic [CNT_W-1:0] cnt_q  [3];
  logic [CNT_W-1:0] cnt_d  [3];

  // held request and sequencer
  tqws_pkg::state_e             state_q, state_d;
  logic                         busy_q, busy_d;
  tqws_pkg::mode_e              mode_q;
  logic [tqws_pkg::ID_W-1:0]    id_q;
  logic [tqws_pkg::TIME_W-1:0]  now_q;
  tqws_pkg::class_e             pend_cls_q, pend_cls_d;

  // output register
  logic                         out_valid_q, out_valid_d;
  logic                         out_load;
  tqws_pkg::status_e            out_status_q, out_status_d;
  tqws_pkg::class_e             out_cls_q, out_cls_d;
  logic [tqws_pkg::ID_W-1:0]    out_id_q, out_id_d;
  logic [tqws_pkg::TIME_W-1:0]  out_req_q, out_req_d;
  logic [tqws_pkg::TIME_W-1:0]  out_wait_q, out_wait_d;
  logic [tqws_pkg::FILL_W-1:0]  out_lf_q, out_df_q, out_ef_q;

  // store port
  tqws_pkg::slot_t              mem [3 * QUEUE_DEPTH];
  tqws_pkg::slot_t              rd_q;
  tqws_pkg::slot_t              wr_data;
  logic                         mem_we, mem_re;
  logic [ADDR_W-1:0]            mem_addr;

  tqws_pkg::pick_t              pick;
  tqws_pkg::class_e             sel_cls;
  logic                         out_free, done, accept;
  logic [EXT_W-1:0]             lf_ext, df_ext, ef_ext;

  tqws_arbiter #(
    .CNT_W (CNT_W)
  ) u_arb (
    .em_cnt_i      (cnt_q[tqws_pkg::CL_EMERGENCY]),
    .ld_cnt_i      (cnt_q[tqws_pkg::CL_LANDING]),
    .dp_cnt_i      (cnt_q[tqws_pkg::CL_DEPARTING]),
    .drain_level_i (drain_q),
    .dep_limit_i   (limit_q),
    .pick_o        (pick)
  );

  assign out_free = !out_valid_q || res_o.ready;

  // class touched by the held request
  always_comb begin
    case (mode_q)
      tqws_pkg::MODE_LANDING:   sel_cls = tqws_pkg::CL_LANDING;
      tqws_pkg::MODE_DEPARTING: sel_cls = tqws_pkg::CL_DEPARTING;
      tqws_pkg::MODE_EMERGENCY: sel_cls = tqws_pkg::CL_EMERGENCY;
      default:                  sel_cls = pick.cls;
    endcase
  end

  // sequencer: push, pop issue, and result assembly
  always_comb begin
    state_d      = state_q;
    pend_cls_d   = pend_cls_q;
    head_d       = head_q;
    tail_d       = tail_q;
    cnt_d        = cnt_q;
    mem_we       = 1'b0;
    mem_re       = 1'b0;
    mem_addr     = '0;
    wr_data.id      = id_q;
    wr_data.arrival = now_q;
    out_load     = 1'b0;
    done         = 1'b0;
    out_status_d = out_status_q;
    out_cls_d    = out_cls_q;
    out_id_d     = out_id_q;
    out_req_d    = out_req_q;
    out_wait_d   = out_wait_q;
    case (state_q)
      tqws_pkg::S_IDLE: begin
        if (busy_q && out_free) begin
          if (mode_q != tqws_pkg::MODE_SERVE) begin
            // push or drop
            out_load     = 1'b1;
            done         = 1'b1;
            out_cls_d    = sel_cls;
            out_id_d     = id_q;
            out_req_d    = '0;
            out_wait_d   = '0;
            if (cnt_q[sel_cls] == CNT_W'(QUEUE_DEPTH)) begin
              out_status_d = tqws_pkg::ST_DROP;
            end else begin
              out_status_d    = tqws_pkg::ST_ENQ;
              mem_we          = 1'b1;
              mem_addr        = ADDR_W'(ADDR_W'(sel_cls) * ADDR_W'(QUEUE_DEPTH)
                                        + ADDR_W'(tail_q[sel_cls]));
              tail_d[sel_cls] = (tail_q[sel_cls] == PTR_W'(QUEUE_DEPTH - 1)) ? '0
                                : tail_q[sel_cls] + 1'b1;
              cnt_d[sel_cls]  = cnt_q[sel_cls] + 1'b1;
            end
          end else if (pick.grant) begin
            // pop: read the head entry, finish next cycle
            mem_re          = 1'b1;
            mem_addr        = ADDR_W'(ADDR_W'(sel_cls) * ADDR_W'(QUEUE_DEPTH)
                                      + ADDR_W'(head_q[sel_cls]));
            head_d[sel_cls] = (head_q[sel_cls] == PTR_W'(QUEUE_DEPTH - 1)) ? '0
                              : head_q[sel_cls] + 1'b1;
            cnt_d[sel_cls]  = cnt_q[sel_cls] - 1'b1;
            pend_cls_d      = sel_cls;
            state_d         = tqws_pkg::S_READ;
          end else begin
            // nothing waiting
            out_load     = 1'b1;
            done         = 1'b1;
            out_status_d = tqws_pkg::ST_IDLE;
            out_cls_d    = tqws_pkg::CL_EMERGENCY;
            out_id_d     = id_q;
            out_req_d    = '0;
            out_wait_d   = '0;
          end
        end
      end
      tqws_pkg::S_READ: begin
        // output register is empty here: it was free when the read was issued
        out_load     = 1'b1;
        done         = 1'b1;
        out_status_d = tqws_pkg::ST_GRANT;
        out_cls_d    = pend_cls_q;
        out_id_d     = rd_q.id;
        out_req_d    = rd_q.arrival - origin_q;
        out_wait_d   = now_q - rd_q.arrival;
        state_d      = tqws_pkg::S_IDLE;
      end
      default: begin
        state_d = tqws_pkg::S_IDLE;
      end
    endcase
  end

  // input register takes a new request when empty or when its request completes
  assign req_i.ready = !busy_q || done;
  assign accept      = req_i.valid && req_i.ready;
  assign busy_d      = accept ? 1'b1 : (done ? 1'b0 : busy_q);

  assign out_valid_d = out_load ? 1'b1 : (res_o.ready ? 1'b0 : out_valid_q);

  // fills after this request, masked to the field width
  assign lf_ext = EXT_W'(cnt_d[tqws_pkg::CL_LANDING]);
  assign df_ext = EXT_W'(cnt_d[tqws_pkg::CL_DEPARTING]);
  assign ef_ext = EXT_W'(cnt_d[tqws_pkg::CL_EMERGENCY]);

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= tqws_pkg::S_IDLE;
      busy_q      <= 1'b0;
      out_valid_q <= 1'b0;
      for (int i = 0; i < 3; i++) begin
        head_q[i] <= '0;
        tail_q[i] <= '0;
        cnt_q[i]  <= '0;
      end
    end else begin
      state_q     <= state_d;
      busy_q      <= busy_d;
      out_valid_q <= out_valid_d;
      head_q      <= head_d;
      tail_q      <= tail_d;
      cnt_q       <= cnt_d;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    pend_cls_q <= pend_cls_d;
    if (accept) begin
      mode_q <= tqws_pkg::mode_e'(req_i.mode);
      id_q   <= req_i.requester_id;
      now_q  <= req_i.now;
    end
    if (out_load) begin
      out_status_q <= out_status_d;
      out_cls_q    <= out_cls_d;
      out_id_q     <= out_id_d;
      out_req_q    <= out_req_d;
      out_wait_q   <= out_wait_d;
      out_lf_q     <= lf_ext[tqws_pkg::FILL_W-1:0];
      out_df_q     <= df_ext[tqws_pkg::FILL_W-1:0];
      out_ef_q     <= ef_ext[tqws_pkg::FILL_W-1:0];
    end
  end

  // entry store, one write or one registered read per cycle
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[mem_addr] <= wr_data;
    end
    if (mem_re) begin
      rd_q <= mem[mem_addr];
    end
  end

  assign res_o.valid          = out_valid_q;
  assign res_o.status         = out_status_q;
  assign res_o.queue_class    = out_cls_q;
  assign res_o.granted_id     = out_id_q;
  assign res_o.rel_time       = out_req_q;
  assign res_o.wait_time      = out_wait_q;
  assign res_o.landing_fill   = out_lf_q;
  assign res_o.departing_fill = out_df_q;
  assign res_o.emergency_fill = out_ef_q;

endmodule

`default_nettype wire

// ===== sv/tqws_checker.sv =====
// tqws_checker: port level assertions for the scheduler, bound to the scheduler core
`default_nettype none

module tqws_checker (
  input wire logic                          clk_i,
  input wire logic                          rst_ni,
  input wire logic                          res_valid_i,
  input wire logic                          res_ready_i,
  input wire logic [1:0]                    status_i,
  input wire logic [1:0]                    queue_class_i,
  input wire logic [tqws_pkg::ID_W-1:0]     granted_id_i,
  input wire logic [tqws_pkg::TIME_W-1:0]   rel_time_i,
  input wire logic [tqws_pkg::TIME_W-1:0]   wait_time_i,
  input wire logic [tqws_pkg::FILL_W-1:0]   landing_fill_i,
  input wire logic [tqws_pkg::FILL_W-1:0]   departing_fill_i,
  input wire logic [tqws_pkg::FILL_W-1:0]   emergency_fill_i
);

  // a stalled result keeps its payload
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_i && !res_ready_i |=> res_valid_i && $stable(status_i) &&
      $stable(queue_class_i) && $stable(granted_id_i) && $stable(rel_time_i) &&
      $stable(wait_time_i) && $stable(landing_fill_i) && $stable(departing_fill_i) &&
      $stable(emergency_fill_i))
    else $error("result changed while stalled");

  // queue class is always one of the three queues
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_i |-> queue_class_i <= 2'(tqws_pkg::CL_DEPARTING))
    else $error("queue class out of range");

  // idle only when every queue is empty, reported against emergency
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_i && status_i == tqws_pkg::ST_IDLE |->
      landing_fill_i == '0 && departing_fill_i == '0 && emergency_fill_i == '0 &&
      queue_class_i == tqws_pkg::CL_EMERGENCY)
    else $error("idle result with a waiting entry");

  // enqueue and drop carry no timing
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_i && (status_i == tqws_pkg::ST_ENQ || status_i == tqws_pkg::ST_DROP) |->
      rel_time_i == '0 && wait_time_i == '0)
    else $error("enqueue result with nonzero times");

endmodule

bind three_queue_watermark_scheduler_core tqws_checker u_tqws_checker (
  .clk_i            (clk_i),
  .rst_ni           (rst_ni),
  .res_valid_i      (res_o.valid),
  .res_ready_i      (res_o.ready),
  .status_i         (res_o.status),
  .queue_class_i    (res_o.queue_class),
  .granted_id_i     (res_o.granted_id),
  .rel_time_i       (res_o.rel_time),
  .wait_time_i      (res_o.wait_time),
  .landing_fill_i   (res_o.landing_fill),
  .departing_fill_i (res_o.departing_fill),
  .emergency_fill_i (res_o.emergency_fill)
);

`default_nettype wire

// ===== sim/tb.sv =====
// tb: randomized check of three_queue_watermark_scheduler_core against a queue-level predictor
`timescale 1ns / 100ps

module tb;

  localparam int unsigned DEPTH = 128;

  // one result item as seen on res_o
  typedef struct packed {
    logic [1:0]                  status;
    logic [1:0]                  cls;
    logic [tqws_pkg::ID_W-1:0]   gid;
    logic [tqws_pkg::TIME_W-1:0] req_time;
    logic [tqws_pkg::TIME_W-1:0] waited;
    logic [tqws_pkg::FILL_W-1:0] landing_fill;
    logic [tqws_pkg::FILL_W-1:0] departing_fill;
    logic [tqws_pkg::FILL_W-1:0] emergency_fill;
  } sched_result_t;

  // predicts scheduler grants and holds the results still owed by the block
  class grant_predictor;
    tqws_pkg::slot_t landing_q[$];
    tqws_pkg::slot_t departing_q[$];
    tqws_pkg::slot_t emergency_q[$];
    logic [tqws_pkg::LEVEL_W-1:0] drain_level = tqws_pkg::LANDING_DRAIN_RST;
    logic [tqws_pkg::LEVEL_W-1:0] departing_limit = tqws_pkg::DEPARTING_LIM_RST;
    logic [tqws_pkg::TIME_W-1:0]  time_origin = tqws_pkg::TIME_ORIGIN_RST;
    sched_result_t owed[$];
    int errors = 0;
    string field_name[8] = '{"status", "queue_class", "granted_id", "rel_time",
                             "wait_time", "landing_fill", "departing_fill",
                             "emergency_fill"};

    // registers keep only their own width
    function void set_config(logic [31:0] drain, logic [31:0] limit, logic [31:0] origin);
      drain_level     = drain[tqws_pkg::LEVEL_W-1:0];
      departing_limit = limit[tqws_pkg::LEVEL_W-1:0];
      time_origin     = origin;
    endfunction

    function int pending();
      return owed.size();
    endfunction

    // push onto one queue, dropped when full
    function tqws_pkg::status_e push_into(ref tqws_pkg::slot_t q[$],
                                          input logic [tqws_pkg::ID_W-1:0] id,
                                          input logic [tqws_pkg::TIME_W-1:0] now);
      tqws_pkg::slot_t s;
      if (q.size() >= DEPTH) return tqws_pkg::ST_DROP;
      s.id      = id;
      s.arrival = now;
      q.push_back(s);
      return tqws_pkg::ST_ENQ;
    endfunction

    // work out the result of one accepted request
    function void note_request(tqws_pkg::mode_e m, logic [tqws_pkg::ID_W-1:0] id,
                               logic [tqws_pkg::TIME_W-1:0] now);
      sched_result_t r;
      tqws_pkg::slot_t s;
      int lf;
      int df;
      bit granted;
      r       = '0;
      r.gid   = id;
      lf      = landing_q.size();
      df      = departing_q.size();
      granted = 1'b1;
      case (m)
        tqws_pkg::MODE_SERVE: begin
          if (emergency_q.size() > 0) begin
            s = emergency_q.pop_front();
            r.cls = tqws_pkg::CL_EMERGENCY;
          end else if (lf > 0 && (df < departing_limit || lf >= drain_level || df == 0)) begin
            s = landing_q.pop_front();
            r.cls = tqws_pkg::CL_LANDING;
          end else if (df > 0) begin
            s = departing_q.pop_front();
            r.cls = tqws_pkg::CL_DEPARTING;
          end else begin
            granted = 1'b0;
          end
          if (granted) begin
            r.status   = tqws_pkg::ST_GRANT;
            r.gid      = s.id;
            r.req_time = s.arrival - time_origin;
            r.waited   = now - s.arrival;
          end else begin
            r.status = tqws_pkg::ST_IDLE;
            r.cls    = tqws_pkg::CL_EMERGENCY;
          end
        end
        tqws_pkg::MODE_LANDING: begin
          r.status = push_into(landing_q, id, now);
          r.cls    = tqws_pkg::CL_LANDING;
        end
        tqws_pkg::MODE_DEPARTING: begin
          r.status = push_into(departing_q, id, now);
          r.cls    = tqws_pkg::CL_DEPARTING;
        end
        default: begin
          r.status = push_into(emergency_q, id, now);
          r.cls    = tqws_pkg::CL_EMERGENCY;
        end
      endcase
      r.landing_fill   = tqws_pkg::FILL_W'(landing_q.size());
      r.departing_fill = tqws_pkg::FILL_W'(departing_q.size());
      r.emergency_fill = tqws_pkg::FILL_W'(emergency_q.size());
      owed.push_back(r);
    endfunction

    // compare one result with the oldest owed one, field by field
    function void check_result(sched_result_t got);
      sched_result_t want;
      logic [31:0] w[8];
      logic [31:0] g[8];
      if (owed.size() == 0) begin
        $display("%0t: result with nothing expected, expected none, actual %p", $time, got);
        errors++;
        return;
      end
      want = owed.pop_front();
      w = '{want.status, want.cls, want.gid, want.req_time, want.waited,
            want.landing_fill, want.departing_fill, want.emergency_fill};
      g = '{got.status, got.cls, got.gid, got.req_time, got.waited,
            got.landing_fill, got.departing_fill, got.emergency_fill};
      foreach (w[i]) begin
        if (w[i] !== g[i]) begin
          $display("%0t: %s mismatch, expected %0h, actual %0h",
                   $time, field_name[i], w[i], g[i]);
          errors++;
        end
      end
    endfunction
  endclass

  logic clk_i;
  logic rst_ni;
  logic cfg_we_i;
  logic [tqws_pkg::CFG_IDX_W-1:0]  cfg_idx_i;
  logic [tqws_pkg::CFG_DATA_W-1:0] cfg_data_i;

  tqws_req_if req ();
  tqws_res_if res ();

  grant_predictor sched = new();
  bit quiet_run = 1'b0;
  int stall_left = 0;
  logic [tqws_pkg::TIME_W-1:0] tick_base = '0;

  three_queue_watermark_scheduler_core #(
    .QUEUE_DEPTH(DEPTH)
  ) dut (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .req_i     (req),
    .res_o     (res),
    .cfg_we_i  (cfg_we_i),
    .cfg_idx_i (cfg_idx_i),
    .cfg_data_i(cfg_data_i)
  );

  // clock
  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // run limit
  initial begin
    #2000000;
    $display("three_queue_watermark_scheduler_core test failed");
    $finish;
  end

  // result side: check accepted results, stall in random bursts
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (res.valid && res.ready) begin
        sched.check_result('{res.status, res.queue_class, res.granted_id, res.rel_time,
                             res.wait_time, res.landing_fill, res.departing_fill,
                             res.emergency_fill});
      end
      if (stall_left > 0) begin
        stall_left--;
        res.ready <= 1'b0;
      end else if (!quiet_run && $urandom_range(0, 5) == 0) begin
        stall_left = $urandom_range(0, 11);
        res.ready <= 1'b0;
      end else begin
        res.ready <= 1'b1;
      end
    end
  end

  // mostly steady time, sometimes a jump anywhere
  function automatic logic [tqws_pkg::TIME_W-1:0] next_time();
    if ($urandom_range(0, 7) == 0) return $urandom();
    tick_base = tick_base + $urandom_range(0, 40);
    return tick_base;
  endfunction

  // level register value with junk above the register width
  function automatic logic [31:0] pick_level();
    logic [tqws_pkg::LEVEL_W-1:0] lvl;
    case ($urandom_range(0, 6))
      0: lvl = 8'd0;
      1: lvl = 8'd1;
      2: lvl = 8'd128;
      3: lvl = 8'd255;
      4: lvl = 8'($urandom_range(1, 128));
      default: lvl = 8'($urandom_range(2, 16));
    endcase
    return {24'($urandom()), lvl};
  endfunction

  function automatic logic [31:0] pick_origin();
    case ($urandom_range(0, 3))
      0: return 32'h0;
      1: return 32'hFFFF_FFFF;
      default: return $urandom();
    endcase
  endfunction

  // send one request, with an occasional gap before it
  task automatic send_request(tqws_pkg::mode_e m, logic [tqws_pkg::ID_W-1:0] id,
                              logic [tqws_pkg::TIME_W-1:0] now);
    if (!quiet_run && $urandom_range(0, 5) == 0) begin
      req.valid <= 1'b0;
      repeat ($urandom_range(1, 12)) @(posedge clk_i);
    end
    req.valid        <= 1'b1;
    req.mode         <= m;
    req.requester_id <= id;
    req.now          <= now;
    @(posedge clk_i);
    while (!req.ready) @(posedge clk_i);
    sched.note_request(m, id, now);
  endtask

  // hold off requests until every owed result has come back
  task automatic wait_drained();
    req.valid <= 1'b0;
    while (sched.pending() != 0) @(posedge clk_i);
    repeat (6) @(posedge clk_i);
  endtask

  // write all three registers, block idle
  task automatic set_config(logic [31:0] drain, logic [31:0] limit, logic [31:0] origin);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= tqws_pkg::CFG_LANDING_DRAIN;
    cfg_data_i <= drain;
    @(posedge clk_i);
    cfg_idx_i  <= tqws_pkg::CFG_DEPARTING_LIM;
    cfg_data_i <= limit;
    @(posedge clk_i);
    cfg_idx_i  <= tqws_pkg::CFG_TIME_ORIGIN;
    cfg_data_i <= origin;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    sched.set_config(drain, limit, origin);
  endtask

  // random mix, enq_pct percent of requests are enqueues
  task automatic run_mix(int count, int enq_pct);
    tqws_pkg::mode_e m;
    int pick;
    repeat (count) begin
      if ($urandom_range(0, 99) < enq_pct) begin
        pick = $urandom_range(0, 19);
        if (pick < 9) m = tqws_pkg::MODE_LANDING;
        else if (pick < 17) m = tqws_pkg::MODE_DEPARTING;
        else m = tqws_pkg::MODE_EMERGENCY;
      end else begin
        m = tqws_pkg::MODE_SERVE;
      end
      send_request(m, 16'($urandom()), next_time());
    end
  endtask

  // fill every queue past full, then serve through emergency into the others
  task automatic fill_round();
    repeat (DEPTH + 2) send_request(tqws_pkg::MODE_LANDING, 16'($urandom()), next_time());
    repeat (DEPTH + 2) send_request(tqws_pkg::MODE_DEPARTING, 16'($urandom()), next_time());
    repeat (DEPTH + 2) send_request(tqws_pkg::MODE_EMERGENCY, 16'($urandom()), next_time());
    repeat (DEPTH + 10) send_request(tqws_pkg::MODE_SERVE, 16'($urandom()), next_time());
  endtask

  // stimulus
  initial begin
    rst_ni           = 1'b0;
    req.valid        = 1'b0;
    req.mode         = tqws_pkg::MODE_LANDING;
    req.requester_id = '0;
    req.now          = '0;
    res.ready        = 1'b0;
    cfg_we_i         = 1'b0;
    cfg_idx_i        = tqws_pkg::CFG_LANDING_DRAIN;
    cfg_data_i       = '0;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // reset settings: idle, field extremes, priority order, time wrap
    send_request(tqws_pkg::MODE_SERVE, 16'hFFFF, 32'h0);
    send_request(tqws_pkg::MODE_LANDING, 16'h0000, 32'h0);
    send_request(tqws_pkg::MODE_LANDING, 16'hFFFF, 32'hFFFF_FFFF);
    send_request(tqws_pkg::MODE_DEPARTING, 16'h1234, 32'd5);
    send_request(tqws_pkg::MODE_EMERGENCY, 16'hA5A5, 32'h8000_0000);
    send_request(tqws_pkg::MODE_SERVE, 16'h0001, 32'h0);
    send_request(tqws_pkg::MODE_SERVE, 16'h0002, 32'd10);
    send_request(tqws_pkg::MODE_SERVE, 16'h0003, 32'h0);
    send_request(tqws_pkg::MODE_SERVE, 16'h0004, 32'h7FFF_FFFF);
    send_request(tqws_pkg::MODE_SERVE, 16'h0000, 32'h0);

    // drain level zero and departing limit zero, junk above register width
    wait_drained();
    set_config(32'hABCD_EF00, 32'h1234_5600, 32'h7FFF_FFFF);
    send_request(tqws_pkg::MODE_LANDING, 16'd1, 32'd100);
    send_request(tqws_pkg::MODE_LANDING, 16'd2, 32'd200);
    send_request(tqws_pkg::MODE_DEPARTING, 16'd3, 32'd300);
    send_request(tqws_pkg::MODE_SERVE, 16'd0, 32'd400);
    send_request(tqws_pkg::MODE_SERVE, 16'd0, 32'd500);
    send_request(tqws_pkg::MODE_SERVE, 16'd0, 32'd50);

    // departing limit zero with a high drain level
    wait_drained();
    set_config(32'd128, 32'd0, 32'hFFFF_FFFF);
    send_request(tqws_pkg::MODE_LANDING, 16'd5, 32'd10);
    send_request(tqws_pkg::MODE_SERVE, 16'd0, 32'd20);
    send_request(tqws_pkg::MODE_DEPARTING, 16'd6, 32'd30);
    send_request(tqws_pkg::MODE_LANDING, 16'd7, 32'd40);
    send_request(tqws_pkg::MODE_SERVE, 16'd0, 32'd50);
    send_request(tqws_pkg::MODE_SERVE, 16'd0, 32'd60);

    // random phases, queues carry over between them
    for (int ph = 0; ph < 7; ph++) begin
      wait_drained();
      set_config(pick_level(), pick_level(), pick_origin());
      quiet_run = (ph % 3 == 2);
      run_mix(30, (ph % 2 == 0) ? 70 : 35);
      if (ph == 2) begin
        wait_drained();
        set_config(32'd128, 32'd1, pick_origin());
        quiet_run = 1'b0;
        fill_round();
      end
    end

    // last part with no idling on either side
    wait_drained();
    set_config(pick_level(), pick_level(), pick_origin());
    quiet_run = 1'b1;
    run_mix(120, 55);
    wait_drained();
    repeat (10) @(posedge clk_i);

    if (sched.errors == 0) begin
      $display("three_queue_watermark_scheduler_core test passed");
    end else begin
      $display("three_queue_watermark_scheduler_core test failed");
    end
    $finish;
  end

endmodule
